// ===== rtl/cnf_formula_scorer_assert.svh =====
// ----------------------------------------------------------------------------
// cnf_formula_scorer assertion macros
// Short forms for the concurrent checks of the scorer top level. They sample
// on clk and are switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CNF_FORMULA_SCORER_ASSERT_SVH
`define CNF_FORMULA_SCORER_ASSERT_SVH

// Same-cycle implication
`define CFS_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cnf_formula_scorer: same-cycle check failed");

// Next-cycle implication
`define CFS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cnf_formula_scorer: next-cycle check failed");

`endif

// ===== rtl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared constants, register codes and controller command type of the CNF
// formula scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

    // Default sizing
    localparam int ATTR_BITS_DEF    = 64;
    localparam int CLAUSE_SLOTS_DEF = 64;
    localparam int COUNT_BITS_DEF   = 20;

    // Fixed field widths
    localparam int MASK_W  = 64;
    localparam int SLOT_W  = 6;
    localparam int THR_W   = 17;
    localparam int CCNT_W  = 7;
    localparam int OUT_W   = 20;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    // Register select (paddr bit 2)
    localparam logic REG_THRESHOLD    = 1'b0;
    localparam logic REG_CLAUSE_COUNT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;   // write clause slot from the input item
        logic start;     // capture row and flags, arm the clause AND
        logic rd_en;     // read one clause slot
        logic tally;     // bump one of the four counters
        logic mult;      // form threshold * class rows
        logic emit;      // load the result register
    } cfs_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cfs_if.sv =====
// ----------------------------------------------------------------------------
// cfs_if
// Valid/ready channels of the scorer: the input item and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfs_item_if;
    import cfs_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [SLOT_W-1:0] clause_slot;
    logic [MASK_W-1:0] ones_mask;
    logic [MASK_W-1:0] zeros_mask;
    logic [MASK_W-1:0] row_bits;
    logic              in_class;
    logic              last_row;

    modport source (
        output valid, operation, clause_slot, ones_mask, zeros_mask,
               row_bits, in_class, last_row,
        input  ready
    );

    modport sink (
        input  valid, operation, clause_slot, ones_mask, zeros_mask,
               row_bits, in_class, last_row,
        output ready
    );
endinterface

interface cfs_result_if;
    import cfs_pkg::*;

    logic             valid;
    logic             ready;
    logic             row_satisfied;
    logic             totals_valid;
    logic [OUT_W-1:0] true_pos;
    logic [OUT_W-1:0] false_neg;
    logic [OUT_W-1:0] true_neg;
    logic [OUT_W-1:0] false_pos;
    logic             efficient;
    logic             covers_class;

    modport source (
        output valid, row_satisfied, totals_valid, true_pos, false_neg,
               true_neg, false_pos, efficient, covers_class,
        input  ready
    );

    modport sink (
        input  valid, row_satisfied, totals_valid, true_pos, false_neg,
               true_neg, false_pos, efficient, covers_class,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfs_ctrl
// Sequencer of the scorer: takes items, walks the clause slots in use one per
// cycle, then steps the counter update, the product and the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_ctrl #(
    parameter int CLAUSE_SLOTS = cfs_pkg::CLAUSE_SLOTS_DEF,
    parameter int ADDR_W       = $clog2(CLAUSE_SLOTS > 1 ? CLAUSE_SLOTS : 2)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       operation,
    output logic                            in_ready,
    input  wire logic [cfs_pkg::CCNT_W-1:0] clause_count,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output cfs_pkg::cfs_cmd_t               cmd,
    output logic [ADDR_W-1:0]               rd_addr
);
    import cfs_pkg::*;

    localparam int LIM_W = (ADDR_W + 1 > CCNT_W) ? ADDR_W + 1 : CCNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_TALLY = 3'd3;
    localparam logic [2:0] S_MULT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [LIM_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [LIM_W-1:0] n_eff;

    // Clauses in use, capped at the slot count
    assign n_eff = (LIM_W'(clause_count) > LIM_W'(CLAUSE_SLOTS))
                 ? LIM_W'(CLAUSE_SLOTS) : LIM_W'(clause_count);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rd_addr   = idx_reg[ADDR_W-1:0];

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        idx_next   = '0;
                        state_next = (n_eff == '0) ? S_TALLY : S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.rd_en = 1'b1;
                if (idx_reg == n_eff - LIM_W'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + LIM_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_TALLY;
            end
            S_TALLY:
            begin
                cmd.tally  = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfs_datapath.sv =====
// ----------------------------------------------------------------------------
// cfs_datapath
// Clause memory, running clause AND, saturating counters, verdict arithmetic
// and the result register of the scorer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_datapath #(
    parameter int ATTR_BITS    = cfs_pkg::ATTR_BITS_DEF,
    parameter int CLAUSE_SLOTS = cfs_pkg::CLAUSE_SLOTS_DEF,
    parameter int COUNT_BITS   = cfs_pkg::COUNT_BITS_DEF,
    parameter int ADDR_W       = $clog2(CLAUSE_SLOTS > 1 ? CLAUSE_SLOTS : 2)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfs_pkg::cfs_cmd_t          cmd,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    input  wire logic [cfs_pkg::THR_W-1:0]  positive_threshold,
    input  wire logic [cfs_pkg::SLOT_W-1:0] clause_slot,
    input  wire logic [cfs_pkg::MASK_W-1:0] ones_mask,
    input  wire logic [cfs_pkg::MASK_W-1:0] zeros_mask,
    input  wire logic [cfs_pkg::MASK_W-1:0] row_bits,
    input  wire logic                       in_class,
    input  wire logic                       last_row,
    output logic                            row_satisfied,
    output logic                            totals_valid,
    output logic [cfs_pkg::OUT_W-1:0]       true_pos,
    output logic [cfs_pkg::OUT_W-1:0]       false_neg,
    output logic [cfs_pkg::OUT_W-1:0]       true_neg,
    output logic [cfs_pkg::OUT_W-1:0]       false_pos,
    output logic                            efficient,
    output logic                            covers_class
);
    import cfs_pkg::*;

    localparam int SC_W = (ADDR_W + 1 > SLOT_W + 1) ? ADDR_W + 1 : SLOT_W + 1;
    localparam int CB   = COUNT_BITS;
    localparam int PW   = THR_W + CB + 1;

    // Clause memory: ones mask in the upper half, zeros mask in the lower
    logic [2*ATTR_BITS-1:0] clause_mem [CLAUSE_SLOTS];
    logic [2*ATTR_BITS-1:0] rd_data_reg;
    logic                   eval_reg;

    logic [ATTR_BITS-1:0] row_reg;
    logic                 class_reg;
    logic                 last_reg;
    logic                 sat_reg;

    logic [CB-1:0] tp_reg, fn_reg, tn_reg, fp_reg;
    logic [PW-1:0] product_reg;

    logic             row_satisfied_reg, totals_valid_reg;
    logic [OUT_W-1:0] true_pos_reg, false_neg_reg, true_neg_reg, false_pos_reg;
    logic             efficient_reg, covers_class_reg;

    logic              slot_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic              clause_hit;
    logic [CB:0]       hits, misses, cls_rows;
    logic              eff, cov;

    assign slot_ok = SC_W'(clause_slot) < SC_W'(CLAUSE_SLOTS);
    assign wr_addr = ADDR_W'(clause_slot);

    // Clause write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_ok)
        begin
            clause_mem[wr_addr] <= {ones_mask[ATTR_BITS-1:0], zeros_mask[ATTR_BITS-1:0]};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= clause_mem[rd_addr];
        end
    end

    // A clause holds when any literal matches the row
    assign clause_hit = |((row_reg & rd_data_reg[2*ATTR_BITS-1:ATTR_BITS])
                        | (~row_reg & rd_data_reg[ATTR_BITS-1:0]));

    // Row capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            row_reg   <= row_bits[ATTR_BITS-1:0];
            class_reg <= in_class;
            last_reg  <= last_row;
        end
    end

    // Read data valid flag and running AND over clauses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg <= 1'b0;
            sat_reg  <= 1'b1;
        end
        else
        begin
            eval_reg <= cmd.rd_en;
            if (cmd.start)
            begin
                sat_reg <= 1'b1;
            end
            else if (eval_reg)
            begin
                sat_reg <= sat_reg & clause_hit;
            end
        end
    end

    // Saturating confusion counters, cleared after the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg <= '0;
            fn_reg <= '0;
            tn_reg <= '0;
            fp_reg <= '0;
        end
        else if (cmd.tally)
        begin
            if (class_reg && sat_reg)
            begin
                if (tp_reg != '1) tp_reg <= tp_reg + CB'(1);
            end
            else if (class_reg)
            begin
                if (fn_reg != '1) fn_reg <= fn_reg + CB'(1);
            end
            else if (!sat_reg)
            begin
                if (tn_reg != '1) tn_reg <= tn_reg + CB'(1);
            end
            else
            begin
                if (fp_reg != '1) fp_reg <= fp_reg + CB'(1);
            end
        end
        else if (cmd.emit && last_reg)
        begin
            tp_reg <= '0;
            fn_reg <= '0;
            tn_reg <= '0;
            fp_reg <= '0;
        end
    end

    // Verdict arithmetic
    assign hits     = (CB+1)'(tp_reg) + (CB+1)'(tn_reg);
    assign misses   = (CB+1)'(fn_reg) + (CB+1)'(fp_reg);
    assign cls_rows = (CB+1)'(tp_reg) + (CB+1)'(fn_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            product_reg <= PW'(positive_threshold) * PW'(cls_rows);
        end
    end

    assign eff = (misses == '0) ? (hits != '0)
                                : ((CB+2)'(hits) > {misses, 1'b0});
    assign cov = (cls_rows != '0) && (PW'({tp_reg, 16'b0}) > product_reg);

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            row_satisfied_reg <= sat_reg;
            totals_valid_reg  <= last_reg;
            true_pos_reg      <= last_reg ? OUT_W'(tp_reg) : '0;
            false_neg_reg     <= last_reg ? OUT_W'(fn_reg) : '0;
            true_neg_reg      <= last_reg ? OUT_W'(tn_reg) : '0;
            false_pos_reg     <= last_reg ? OUT_W'(fp_reg) : '0;
            efficient_reg     <= last_reg & eff;
            covers_class_reg  <= last_reg & cov;
        end
    end

    assign row_satisfied = row_satisfied_reg;
    assign totals_valid  = totals_valid_reg;
    assign true_pos      = true_pos_reg;
    assign false_neg     = false_neg_reg;
    assign true_neg      = true_neg_reg;
    assign false_pos     = false_pos_reg;
    assign efficient     = efficient_reg;
    assign covers_class  = covers_class_reg;

endmodule

`default_nettype wire

// ===== rtl/cnf_formula_scorer.sv =====
// ----------------------------------------------------------------------------
// cnf_formula_scorer
// Scores attribute rows against a CNF formula held in clause slots and keeps
// confusion counts with coverage and efficiency verdicts.
// ----------------------------------------------------------------------------
//  channel  | kind          | carries
//  ---------+---------------+---------------------------------------------
//  item     | valid/ready in| clause load or row to score
//  result   | valid/ready out| row verdict, totals on the last row
//  apb      | APB write/read| positive_threshold (0x0), clause_count (0x4)
//
//  A load is written as it is taken. A score item reads the N clauses in use
//  (min of clause_count and CLAUSE_SLOTS), then tallies, multiplies and loads
//  the result; the clause memory gives one slot per cycle to the running AND.
//  The result register lets the next item in while a result waits; a score
//  item stalls in its last step only when the previous result is still held.
//  Reset is asynchronous and clears control, counters and configuration registers; clause
//  slots hold nothing defined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module cnf_formula_scorer #(
    parameter int ATTR_BITS    = cfs_pkg::ATTR_BITS_DEF,
    parameter int CLAUSE_SLOTS = cfs_pkg::CLAUSE_SLOTS_DEF,
    parameter int COUNT_BITS   = cfs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cfs_item_if.sink                         item,
    cfs_result_if.source                     result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [cfs_pkg::PDATA_W-1:0] pwdata,
    output logic [cfs_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import cfs_pkg::*;

    `include "cnf_formula_scorer_assert.svh"

    localparam int ADDR_W = $clog2(CLAUSE_SLOTS > 1 ? CLAUSE_SLOTS : 2);

    logic [THR_W-1:0]  threshold_reg;
    logic [CCNT_W-1:0] clause_count_reg;
    logic              cfg_wr;
    cfs_cmd_t          cmd;
    logic [ADDR_W-1:0] rd_addr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            clause_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_THRESHOLD)
            begin
                threshold_reg <= pwdata[THR_W-1:0];
            end
            else
            begin
                clause_count_reg <= pwdata[CCNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? PDATA_W'(threshold_reg)
                                                : PDATA_W'(clause_count_reg);

    // Sequencer
    cfs_ctrl #(
        .CLAUSE_SLOTS (CLAUSE_SLOTS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item.valid),
        .operation    (item.operation),
        .in_ready     (item.ready),
        .clause_count (clause_count_reg),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .cmd          (cmd),
        .rd_addr      (rd_addr)
    );

    // Datapath
    cfs_datapath #(
        .ATTR_BITS    (ATTR_BITS),
        .CLAUSE_SLOTS (CLAUSE_SLOTS),
        .COUNT_BITS   (COUNT_BITS),
        .ADDR_W       (ADDR_W)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .rd_addr            (rd_addr),
        .positive_threshold (threshold_reg),
        .clause_slot        (item.clause_slot),
        .ones_mask          (item.ones_mask),
        .zeros_mask         (item.zeros_mask),
        .row_bits           (item.row_bits),
        .in_class           (item.in_class),
        .last_row           (item.last_row),
        .row_satisfied      (result.row_satisfied),
        .totals_valid       (result.totals_valid),
        .true_pos           (result.true_pos),
        .false_neg          (result.false_neg),
        .true_neg           (result.true_neg),
        .false_pos          (result.false_pos),
        .efficient          (result.efficient),
        .covers_class       (result.covers_class)
    );

    // Checks
    `CFS_ASSERT_NEXT(a_score_busy, item.valid && item.ready && item.operation == OP_SCORE, !item.ready)
    `CFS_ASSERT_NEXT(a_load_free, item.valid && item.ready && item.operation == OP_LOAD, item.ready)
    `CFS_ASSERT_NOW(a_cover_needs_tp, result.valid && result.covers_class, result.true_pos != '0)
    `CFS_ASSERT_NOW(a_no_totals, result.valid && !result.totals_valid, !result.efficient && !result.covers_class && result.true_pos == '0)

endmodule

`default_nettype wire

// ===== tb/sv/cnf_formula_scorer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cnf_formula_scorer_tb
// Self-checking bench for the CNF formula scorer. Clause loads and scored
// rows go in through a queue-fed driver; a monitor compares each result item
// with a prediction made when the input item was accepted. Both channels
// idle at random, the registers are rewritten between phases over the APB
// port and read back.
// ----------------------------------------------------------------------------

module cnf_formula_scorer_tb;
    import cfs_pkg::*;

    localparam int SLOTS     = CLAUSE_SLOTS_DEF;
    localparam int CNT_W     = COUNT_BITS_DEF;
    localparam int BIT_IDX_W = $clog2(MASK_W);

    localparam logic [PADDR_W-1:0] THR_ADDR = {REG_THRESHOLD, 2'b00};
    localparam logic [PADDR_W-1:0] CNT_ADDR = {REG_CLAUSE_COUNT, 2'b00};

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] clause_slot;
        logic [MASK_W-1:0] ones_mask;
        logic [MASK_W-1:0] zeros_mask;
        logic [MASK_W-1:0] row_bits;
        logic              in_class;
        logic              last_row;
    } scorer_item_t;

    typedef struct packed {
        logic             row_satisfied;
        logic             totals_valid;
        logic [OUT_W-1:0] true_pos;
        logic [OUT_W-1:0] false_neg;
        logic [OUT_W-1:0] true_neg;
        logic [OUT_W-1:0] false_pos;
        logic             efficient;
        logic             covers_class;
    } row_verdict_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cfs_item_if   item_if ();
    cfs_result_if result_if ();

    cnf_formula_scorer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Items waiting for the driver, verdicts waiting for the monitor
    scorer_item_t pending_items[$];
    row_verdict_t expected_verdicts[$];
    scorer_item_t held_item;
    logic         item_held;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;

    // Predictor state: clause store, confusion counters, register copies
    logic [MASK_W-1:0] slot_ones [SLOTS];
    logic [MASK_W-1:0] slot_zeros[SLOTS];
    logic [CNT_W-1:0]  cnt_tp, cnt_fn, cnt_tn, cnt_fp;
    logic [THR_W-1:0]  cfg_threshold;
    logic [CCNT_W-1:0] cfg_clauses;

    // Stimulus side copy of the clause store, for aimed rows
    logic [MASK_W-1:0] gen_ones [SLOTS];
    logic [MASK_W-1:0] gen_zeros[SLOTS];
    logic              gen_loaded[SLOTS];

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 50)
            $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic match_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Apply one accepted item; score items leave one verdict behind
    function automatic void tally_item(input scorer_item_t it);
        row_verdict_t      v;
        logic              sat;
        logic [MASK_W-1:0] hit;
        logic [63:0]       tp, fn, tn, fp, hits, misses, cls_rows;
        int                n;
        int                i;
        if (it.operation == OP_LOAD)
        begin
            slot_ones[it.clause_slot]  = it.ones_mask;
            slot_zeros[it.clause_slot] = it.zeros_mask;
            return;
        end
        n   = (cfg_clauses > SLOTS) ? SLOTS : int'(cfg_clauses);
        sat = 1'b1;
        for (i = 0; i < n; i++)
        begin
            hit = (it.row_bits & slot_ones[i]) | (~it.row_bits & slot_zeros[i]);
            if (hit == '0)
                sat = 1'b0;
        end
        // saturating confusion counters
        if (it.in_class && sat)
        begin
            if (cnt_tp != '1) cnt_tp = cnt_tp + CNT_W'(1);
        end
        else if (it.in_class)
        begin
            if (cnt_fn != '1) cnt_fn = cnt_fn + CNT_W'(1);
        end
        else if (!sat)
        begin
            if (cnt_tn != '1) cnt_tn = cnt_tn + CNT_W'(1);
        end
        else
        begin
            if (cnt_fp != '1) cnt_fp = cnt_fp + CNT_W'(1);
        end
        v = '0;
        v.row_satisfied = sat;
        if (it.last_row)
        begin
            tp       = 64'(cnt_tp);
            fn       = 64'(cnt_fn);
            tn       = 64'(cnt_tn);
            fp       = 64'(cnt_fp);
            hits     = tp + tn;
            misses   = fn + fp;
            cls_rows = tp + fn;
            v.totals_valid = 1'b1;
            v.true_pos     = cnt_tp[OUT_W-1:0];
            v.false_neg    = cnt_fn[OUT_W-1:0];
            v.true_neg     = cnt_tn[OUT_W-1:0];
            v.false_pos    = cnt_fp[OUT_W-1:0];
            v.efficient    = (misses == 64'd0) ? (hits != 64'd0)
                                               : (hits > 64'd2 * misses);
            v.covers_class = (cls_rows != 64'd0) &&
                             ((tp << 16) > {47'b0, cfg_threshold} * cls_rows);
            cnt_tp = '0;
            cnt_fn = '0;
            cnt_tn = '0;
            cnt_fp = '0;
        end
        expected_verdicts.push_back(v);
    endfunction

    // Driver: hands items over, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        scorer_item_t next_item;
        logic         free;
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
        end
        else
        begin
            free = !item_if.valid || item_if.ready;
            if (item_if.valid && item_if.ready)
            begin
                tally_item(held_item);
                item_held = 1'b0;
            end
            if (free)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    held_item = next_item;
                    item_held = 1'b1;
                    item_if.operation   <= next_item.operation;
                    item_if.clause_slot <= next_item.clause_slot;
                    item_if.ones_mask   <= next_item.ones_mask;
                    item_if.zeros_mask  <= next_item.zeros_mask;
                    item_if.row_bits    <= next_item.row_bits;
                    item_if.in_class    <= next_item.in_class;
                    item_if.last_row    <= next_item.last_row;
                    item_if.valid       <= 1'b1;
                end
                else
                begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, field by field comparison
    always @(posedge clk or negedge rst_n)
    begin : check_results
        row_verdict_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 64'd0, 64'd0);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    match_field("row_satisfied", 64'(result_if.row_satisfied),
                                64'(want.row_satisfied));
                    match_field("totals_valid", 64'(result_if.totals_valid),
                                64'(want.totals_valid));
                    match_field("true_pos", 64'(result_if.true_pos),
                                64'(want.true_pos));
                    match_field("false_neg", 64'(result_if.false_neg),
                                64'(want.false_neg));
                    match_field("true_neg", 64'(result_if.true_neg),
                                64'(want.true_neg));
                    match_field("false_pos", 64'(result_if.false_pos),
                                64'(want.false_pos));
                    match_field("efficient", 64'(result_if.efficient),
                                64'(want.efficient));
                    match_field("covers_class", 64'(result_if.covers_class),
                                64'(want.covers_class));
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_held || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // APB write then read back
    task automatic write_reg(input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        match_field("register readback", 64'(prdata), 64'(data));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the block idle; loads leave no result, so
    // wait for the queues to drain and the block to settle before writing
    task automatic set_config(input logic [THR_W-1:0] thr, input logic [CCNT_W-1:0] cc);
        wait_drained();
        repeat (10) @(posedge clk);
        write_reg(THR_ADDR, {{(PDATA_W-THR_W){1'b0}}, thr});
        cfg_threshold = thr;
        write_reg(CNT_ADDR, {{(PDATA_W-CCNT_W){1'b0}}, cc});
        cfg_clauses = cc;
    endtask

    task automatic push_load(input int slot, input logic [MASK_W-1:0] ones,
                             input logic [MASK_W-1:0] zeros);
        scorer_item_t it;
        it             = '0;
        it.operation   = OP_LOAD;
        it.clause_slot = slot[SLOT_W-1:0];
        it.ones_mask   = ones;
        it.zeros_mask  = zeros;
        it.row_bits    = {$urandom, $urandom};
        gen_ones[slot]   = ones;
        gen_zeros[slot]  = zeros;
        gen_loaded[slot] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic push_score(input logic [MASK_W-1:0] row, input logic cls,
                              input logic last);
        scorer_item_t it;
        it           = '0;
        it.operation = OP_SCORE;
        it.row_bits  = row;
        it.in_class  = cls;
        it.last_row  = last;
        // unused load fields carry noise
        it.clause_slot = SLOT_W'($urandom_range(SLOTS - 1));
        it.ones_mask   = {$urandom, $urandom};
        it.zeros_mask  = {$urandom, $urandom};
        pending_items.push_back(it);
    endtask

    // Mostly short clauses, some wide ones; never empty
    function automatic void make_clause(output logic [MASK_W-1:0] ones,
                                        output logic [MASK_W-1:0] zeros);
        int pick;
        int lits;
        int j;
        pick  = $urandom_range(9);
        ones  = '0;
        zeros = '0;
        if (pick == 7)
        begin
            ones  = {$urandom, $urandom};
            zeros = {$urandom, $urandom};
        end
        else if (pick == 8)
        begin
            ones = {$urandom, $urandom};
        end
        else
        begin
            lits = $urandom_range(4, 1);
            for (j = 0; j < lits; j++)
            begin
                if (pick == 9 || $urandom_range(1) == 1)
                    ones[BIT_IDX_W'($urandom_range(MASK_W - 1))] = 1'b1;
                else
                    zeros[BIT_IDX_W'($urandom_range(MASK_W - 1))] = 1'b1;
            end
        end
        if (ones == '0 && zeros == '0)
            ones[0] = 1'b1;
    endfunction

    // Random row nudged towards satisfying the clauses in use
    function automatic logic [MASK_W-1:0] aimed_row();
        logic [MASK_W-1:0] row;
        int                n;
        int                pass;
        int                i;
        row = {$urandom, $urandom};
        n   = (cfg_clauses > SLOTS) ? SLOTS : int'(cfg_clauses);
        for (pass = 0; pass < 2; pass++)
            for (i = 0; i < n; i++)
                if (((row & gen_ones[i]) | (~row & gen_zeros[i])) == '0)
                begin
                    if (gen_ones[i] != '0)
                        row = row | (gen_ones[i] & (~gen_ones[i] + MASK_W'(1)));
                    else
                        row = row & ~(gen_zeros[i] & (~gen_zeros[i] + MASK_W'(1)));
                end
        return row;
    endfunction

    // Slots in use must hold a non-empty clause before any row is scored
    task automatic prepare_slots();
        logic [MASK_W-1:0] ones, zeros;
        int                n;
        int                s;
        n = (cfg_clauses > SLOTS) ? SLOTS : int'(cfg_clauses);
        for (s = 0; s < n; s++)
            if (!gen_loaded[s] || (gen_ones[s] == '0 && gen_zeros[s] == '0))
            begin
                make_clause(ones, zeros);
                push_load(s, ones, zeros);
            end
    endtask

    task automatic random_phase(input logic [THR_W-1:0] thr, input logic [CCNT_W-1:0] cc,
                                input int count, input logic hold_midway);
        logic [MASK_W-1:0] ones, zeros, row;
        int                k;
        int                pick;
        set_config(thr, cc);
        prepare_slots();
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                make_clause(ones, zeros);
                push_load($urandom_range(SLOTS - 1), ones, zeros);
            end
            else
            begin
                pick = $urandom_range(9);
                if (pick < 5)
                    row = aimed_row();
                else if (pick == 5)
                    row = '0;
                else if (pick == 6)
                    row = '1;
                else
                    row = {$urandom, $urandom};
                push_score(row, 1'($urandom_range(1)), $urandom_range(11) == 0);
            end
            // sender holds off until the block has answered everything
            if (hold_midway && k == count / 2)
                wait_drained();
        end
        push_score(aimed_row(), 1'($urandom_range(1)), 1'b1);
    endtask

    initial
    begin : run_test
        int s;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        item_if.valid       = 1'b0;
        item_if.operation   = OP_LOAD;
        item_if.clause_slot = '0;
        item_if.ones_mask   = '0;
        item_if.zeros_mask  = '0;
        item_if.row_bits    = '0;
        item_if.in_class    = 1'b0;
        item_if.last_row    = 1'b0;
        result_if.ready     = 1'b0;
        item_held      = 1'b0;
        mismatch_count = 0;
        cnt_tp = '0;
        cnt_fn = '0;
        cnt_tn = '0;
        cnt_fp = '0;
        cfg_threshold = '0;
        cfg_clauses   = '0;
        for (s = 0; s < SLOTS; s++)
        begin
            gen_loaded[s] = 1'b0;
            gen_ones[s]   = '0;
            gen_zeros[s]  = '0;
        end
        send_idle_pct = 28;
        recv_idle_pct = 87;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty formula: every row holds. Extreme clauses, an empty one in slot 2
        push_load(0, '1, '0);
        push_load(1, '0, '1);
        push_load(2, '0, '0);
        push_load(SLOTS - 1, {1'b1, 63'b0}, 64'd1);
        push_score('1, 1'b0, 1'b0);
        push_score('0, 1'b1, 1'b1);
        push_score({$urandom, $urandom}, 1'b1, 1'b1);

        // Two clauses; coverage exactly at threshold, then no class rows
        set_config(THR_W'(32768), CCNT_W'(2));
        push_score({32{2'b01}}, 1'b1, 1'b0);
        push_score('0, 1'b1, 1'b1);
        push_score('1, 1'b0, 1'b1);

        // Empty clause in use: nothing holds; full-scale threshold
        set_config(THR_W'(65536), CCNT_W'(3));
        push_score({$urandom, $urandom}, 1'b0, 1'b0);
        push_score({$urandom, $urandom}, 1'b1, 1'b1);

        random_phase(THR_W'(0), CCNT_W'(SLOTS), 330, 1'b1);
        random_phase(THR_W'(65536), '1, 330, 1'b0);

        send_idle_pct = 87;
        recv_idle_pct = 28;
        random_phase(THR_W'($urandom_range(65536)), CCNT_W'(1), 330, 1'b0);
        random_phase(THR_W'($urandom_range(65536)), CCNT_W'($urandom_range(SLOTS)),
                     330, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(THR_W'($urandom_range(65536)),
                     CCNT_W'($urandom_range(127, SLOTS + 1)), 330, 1'b0);
        random_phase(THR_W'($urandom_range(65536)), CCNT_W'($urandom_range(8, 1)),
                     330, 1'b0);

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("cnf_formula_scorer_tb passed");
        else
            $display("cnf_formula_scorer_tb failed");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("cnf_formula_scorer_tb failed");
        $finish;
    end

endmodule
